// ----- hdl/dmf_pkg.sv -----
// shared types and constants for the max-flow engine
`default_nettype none
package dmf_pkg;

  localparam int ResW = 16;
  localparam int ValW = 28;

  localparam logic [1:0] ActAdd  = 2'd0;
  localparam logic [1:0] ActRun  = 2'd1;
  localparam logic [1:0] ActRead = 2'd2;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StBad  = 2'd2;

  localparam logic       CfgSource = 1'b0;
  localparam logic       CfgSink   = 1'b1;

  localparam logic [ResW-1:0] PushLimit = 16'hFFFF;
  localparam logic [ValW-1:0] FlowMax   = 28'h0FFFFFFF;

  typedef enum logic [24:0] {
    S_HCLR  = 25'h0000001,
    S_IDLE  = 25'h0000002,
    S_ADD0  = 25'h0000004,
    S_ADD1  = 25'h0000008,
    S_ADD2  = 25'h0000010,
    S_RD0   = 25'h0000020,
    S_RD1   = 25'h0000040,
    S_BCLR  = 25'h0000080,
    S_BINIT = 25'h0000100,
    S_BDEQ  = 25'h0000200,
    S_BX    = 25'h0000400,
    S_BH    = 25'h0000800,
    S_BE    = 25'h0001000,
    S_BY    = 25'h0002000,
    S_BL    = 25'h0004000,
    S_DST   = 25'h0008000,
    S_DS2   = 25'h0010000,
    S_DE    = 25'h0020000,
    S_DY    = 25'h0040000,
    S_DL    = 25'h0080000,
    S_DPH   = 25'h0100000,
    S_DRET  = 25'h0200000,
    S_DP1   = 25'h0400000,
    S_DP2   = 25'h0800000,
    S_OUT   = 25'h1000000
  } state_e;

endpackage
`default_nettype wire

// ----- hdl/dinic_max_flow_engine_top.sv -----
// top level of the dinic max-flow engine
`default_nettype none
// The engine holds a directed graph in on-chip rams and answers one request at a time. After
// reset it clears the node list heads before it takes the first request. An add writes a
// forward and a reverse edge, and a read returns the residual capacity of one edge. A run is
// data dependent: each level pass clears the level ram and seeds the queue with the source,
// then dequeues nodes and scans their edges; each push round starts at the source, then tries
// edges, descends into nodes and returns from them. Every step is bounded by the single read
// port of each ram and its registered read. The total flow saturates at 0x0FFFFFFF and each
// push starts with a limit of 0xFFFF.
module dinic_max_flow_engine_top #(
  parameter int NODES      = 128,
  parameter int EDGE_SLOTS = 8192
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_index_i,
  input  wire logic [6:0]                cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [1:0]                action_i,
  input  wire logic [6:0]                edge_from_i,
  input  wire logic [6:0]                edge_to_i,
  input  wire logic [dmf_pkg::ResW-1:0]  capacity_i,
  input  wire logic [11:0]               edge_number_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic      [dmf_pkg::ValW-1:0]  result_value_o,
  output logic      [1:0]                status_o
);
  import dmf_pkg::*;

  localparam int NW    = $clog2(NODES);
  localparam int EW    = $clog2(EDGE_SLOTS);
  localparam int LW    = NW + 2;
  localparam int PAIRS = (EDGE_SLOTS + 1) / 2;
  localparam int PW    = $clog2(PAIRS);
  localparam int KW    = EW + NW;
  localparam int FW    = NW + EW + 2 * ResW;
  localparam int XW    = (EW > 12) ? EW + 1 : 13;

  typedef logic [NW-1:0] fold_t [128];

  function automatic fold_t build_fold();
    fold_t tab;
    for (int i = 0; i < 128; i++) begin
      tab[i] = NW'(i % NODES);
    end
    return tab;
  endfunction

  localparam fold_t FoldTab = build_fold();

  function automatic logic [2*ResW-1:0] pack_pair(input logic odd, input logic [ResW-1:0] own,
                                                  input logic [ResW-1:0] twin);
    return odd ? {own, twin} : {twin, own};
  endfunction

  function automatic logic [ResW-1:0] sat_add(input logic [ResW-1:0] a,
                                              input logic [ResW-1:0] b);
    logic [ResW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ResW] ? PushLimit : s[ResW-1:0];
  endfunction

  state_e state_q, state_d;
  logic [6:0] src_q, snk_q;
  logic [NW-1:0] x_q, x_d, y_q, y_d, s_q, s_d, t_q, t_d, clr_q, clr_d;
  logic [NW-1:0] ny_q, ny_d, fnode_q, fnode_d, sp_q, sp_d;
  logic [NW:0] qh_q, qh_d, qt_q, qt_d;
  logic [ResW-1:0] cap_q, cap_d, rf_q, rf_d, rr_q, rr_d;
  logic [ResW-1:0] flim_q, flim_d, ftemp_q, ftemp_d, ret_q, ret_d;
  logic [PW-1:0] n_q, n_d;
  logic [LW-1:0] lx_q, lx_d;
  logic [EW-1:0] fedge_q, fedge_d, nxt_q, nxt_d, ecnt_q, ecnt_d;
  logic [ValW-1:0] total_q, total_d, val_q, val_d, rv_q;
  logic [1:0] stat_q, stat_d, st_q;
  logic ov_q;

  logic head_we, lvl_we, que_we, stk_we, lnk_we, res_we;
  logic [NW-1:0] head_wa, head_ra, lvl_wa, lvl_ra, que_wa, que_ra, stk_wa, stk_ra;
  logic [EW-1:0] head_wd, head_rd, lnk_wa, lnk_ra;
  logic [LW-1:0] lvl_wd, lvl_rd;
  logic [NW-1:0] que_wd, que_rd;
  logic [FW-1:0] stk_wd, stk_rd;
  logic [KW-1:0] lnk_wd, lnk_rd;
  logic [PW-1:0] res_wa, res_ra;
  logic [2*ResW-1:0] res_wd, res_rd;

  logic out_free;
  logic [EW-1:0] f_edge, r_edge;
  logic [XW-1:0] num_x;
  logic [ResW-1:0] lim, ret;
  logic [ValW:0] tsum;

  assign out_free = !ov_q || !out_stall_i;
  assign f_edge   = ecnt_q + EW'(1);
  assign r_edge   = ecnt_q + EW'(2);
  assign num_x    = XW'(edge_number_i);
  assign lim      = (rf_q < ftemp_q) ? rf_q : ftemp_q;
  assign ret      = flim_q - ftemp_q;
  assign tsum     = {1'b0, total_q} + (ValW + 1)'(ret);

  dmf_ram #(.WIDTH(EW), .DEPTH(NODES)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_wa), .wdata_i(head_wd), .raddr_i(head_ra),
    .rdata_o(head_rd));
  dmf_ram #(.WIDTH(LW), .DEPTH(NODES)) u_lvl (
    .clk_i, .we_i(lvl_we), .waddr_i(lvl_wa), .wdata_i(lvl_wd), .raddr_i(lvl_ra),
    .rdata_o(lvl_rd));
  dmf_ram #(.WIDTH(NW), .DEPTH(NODES)) u_que (
    .clk_i, .we_i(que_we), .waddr_i(que_wa), .wdata_i(que_wd), .raddr_i(que_ra),
    .rdata_o(que_rd));
  dmf_ram #(.WIDTH(FW), .DEPTH(NODES)) u_stk (
    .clk_i, .we_i(stk_we), .waddr_i(stk_wa), .wdata_i(stk_wd), .raddr_i(stk_ra),
    .rdata_o(stk_rd));
  dmf_ram #(.WIDTH(KW), .DEPTH(EDGE_SLOTS)) u_lnk (
    .clk_i, .we_i(lnk_we), .waddr_i(lnk_wa), .wdata_i(lnk_wd), .raddr_i(lnk_ra),
    .rdata_o(lnk_rd));
  dmf_ram #(.WIDTH(2 * ResW), .DEPTH(PAIRS)) u_res (
    .clk_i, .we_i(res_we), .waddr_i(res_wa), .wdata_i(res_wd), .raddr_i(res_ra),
    .rdata_o(res_rd));

  always_comb begin
    state_d = state_q;
    x_d = x_q; y_d = y_q; s_d = s_q; t_d = t_q; clr_d = clr_q;
    ny_d = ny_q; fnode_d = fnode_q; sp_d = sp_q; qh_d = qh_q; qt_d = qt_q;
    cap_d = cap_q; rf_d = rf_q; rr_d = rr_q; flim_d = flim_q; ftemp_d = ftemp_q;
    ret_d = ret_q; n_d = n_q; lx_d = lx_q; fedge_d = fedge_q; nxt_d = nxt_q;
    ecnt_d = ecnt_q; total_d = total_q; val_d = val_q; stat_d = stat_q;
    head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0;
    lvl_we = 1'b0; lvl_wa = '0; lvl_wd = '0; lvl_ra = '0;
    que_we = 1'b0; que_wa = '0; que_wd = '0; que_ra = '0;
    stk_we = 1'b0; stk_wa = '0; stk_wd = '0; stk_ra = '0;
    lnk_we = 1'b0; lnk_wa = '0; lnk_wd = '0; lnk_ra = '0;
    res_we = 1'b0; res_wa = '0; res_wd = '0; res_ra = '0;
    case (state_q)
      S_HCLR: begin
        head_we = 1'b1;
        head_wa = clr_q;
        clr_d   = clr_q + NW'(1);
        if (clr_q == NW'(NODES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        val_d  = '0;
        stat_d = StOk;
        if (in_valid_i) begin
          case (action_i)
            ActAdd: begin
              if ((EW + 1)'(ecnt_q) + (EW + 1)'(2) < (EW + 1)'(EDGE_SLOTS)) begin
                x_d     = FoldTab[edge_from_i];
                y_d     = FoldTab[edge_to_i];
                cap_d   = capacity_i;
                state_d = S_ADD0;
              end else begin
                stat_d  = StFull;
                state_d = S_OUT;
              end
            end
            ActRun: begin
              s_d     = FoldTab[src_q];
              t_d     = FoldTab[snk_q];
              total_d = '0;
              clr_d   = '0;
              state_d = S_BCLR;
            end
            ActRead: begin
              if (edge_number_i >= 12'd2 && !edge_number_i[0] && num_x < XW'(ecnt_q)) begin
                n_d     = PW'(edge_number_i >> 1);
                state_d = S_RD0;
              end else begin
                stat_d  = StBad;
                state_d = S_OUT;
              end
            end
            default: begin
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_ADD0: begin
        head_ra = x_q;
        state_d = S_ADD1;
      end
      S_ADD1: begin
        lnk_we  = 1'b1;
        lnk_wa  = f_edge;
        lnk_wd  = {y_q, head_rd};
        head_we = 1'b1;
        head_wa = x_q;
        head_wd = f_edge;
        head_ra = y_q;
        res_we  = 1'b1;
        res_wa  = PW'(f_edge >> 1);
        res_wd  = pack_pair(f_edge[0], cap_q, '0);
        state_d = S_ADD2;
      end
      S_ADD2: begin
        lnk_we  = 1'b1;
        lnk_wa  = r_edge;
        lnk_wd  = {x_q, (x_q == y_q) ? f_edge : head_rd};
        head_we = 1'b1;
        head_wa = y_q;
        head_wd = r_edge;
        ecnt_d  = r_edge;
        val_d   = ValW'(f_edge);
        state_d = S_OUT;
      end
      S_RD0: begin
        res_ra  = n_q;
        state_d = S_RD1;
      end
      S_RD1: begin
        val_d   = ValW'(res_rd[ResW-1:0]);
        state_d = S_OUT;
      end
      S_BCLR: begin
        lvl_we = 1'b1;
        lvl_wa = clr_q;
        clr_d  = clr_q + NW'(1);
        if (clr_q == NW'(NODES - 1)) begin
          state_d = S_BINIT;
        end
      end
      S_BINIT: begin
        lvl_we  = 1'b1;
        lvl_wa  = s_q;
        lvl_wd  = LW'(1);
        que_we  = 1'b1;
        que_wd  = s_q;
        qh_d    = '0;
        qt_d    = (NW + 1)'(1);
        state_d = S_BDEQ;
      end
      S_BDEQ: begin
        if (qh_q == qt_q) begin
          val_d   = total_q;
          state_d = S_OUT;
        end else begin
          que_ra  = qh_q[NW-1:0];
          qh_d    = qh_q + (NW + 1)'(1);
          state_d = S_BX;
        end
      end
      S_BX: begin
        head_ra = que_rd;
        lvl_ra  = que_rd;
        state_d = S_BH;
      end
      S_BH: begin
        lx_d    = lvl_rd;
        fedge_d = head_rd;
        state_d = S_BE;
      end
      S_BE: begin
        if (fedge_q == '0) begin
          state_d = S_BDEQ;
        end else begin
          lnk_ra  = fedge_q;
          res_ra  = PW'(fedge_q >> 1);
          state_d = S_BY;
        end
      end
      S_BY, S_DY: begin
        ny_d    = lnk_rd[KW-1 -: NW];
        nxt_d   = lnk_rd[EW-1:0];
        rf_d    = fedge_q[0] ? res_rd[2*ResW-1:ResW] : res_rd[ResW-1:0];
        rr_d    = fedge_q[0] ? res_rd[ResW-1:0] : res_rd[2*ResW-1:ResW];
        lvl_ra  = lnk_rd[KW-1 -: NW];
        state_d = (state_q == S_BY) ? S_BL : S_DL;
      end
      S_BL: begin
        fedge_d = nxt_q;
        state_d = S_BE;
        if (rf_q != '0 && lvl_rd == '0) begin
          lvl_we = 1'b1;
          lvl_wa = ny_q;
          lvl_wd = lx_q + LW'(1);
          if (ny_q == t_q) begin
            state_d = S_DST;
          end else if (qt_q < (NW + 1)'(NODES)) begin
            que_we = 1'b1;
            que_wa = qt_q[NW-1:0];
            que_wd = ny_q;
            qt_d   = qt_q + (NW + 1)'(1);
          end
        end
      end
      S_DST: begin
        head_ra = s_q;
        state_d = S_DS2;
      end
      S_DS2: begin
        fnode_d = s_q;
        fedge_d = head_rd;
        flim_d  = PushLimit;
        ftemp_d = PushLimit;
        sp_d    = '0;
        state_d = S_DE;
      end
      S_DE: begin
        if (fedge_q != '0 && ftemp_q != '0) begin
          lnk_ra  = fedge_q;
          res_ra  = PW'(fedge_q >> 1);
          state_d = S_DY;
        end else begin
          state_d = S_DRET;
        end
      end
      S_DL: begin
        fedge_d = nxt_q;
        state_d = S_DE;
        if (rf_q != '0 && lvl_rd == LW'(sp_q) + LW'(2)) begin
          if (ny_q == t_q) begin
            res_we  = 1'b1;
            res_wa  = PW'(fedge_q >> 1);
            res_wd  = pack_pair(fedge_q[0], rf_q - lim, sat_add(rr_q, lim));
            ftemp_d = ftemp_q - lim;
          end else if (sp_q != NW'(NODES - 1)) begin
            stk_we  = 1'b1;
            stk_wa  = sp_q;
            stk_wd  = {fnode_q, fedge_q, flim_q, ftemp_q};
            sp_d    = sp_q + NW'(1);
            fnode_d = ny_q;
            fedge_d = fedge_q;
            flim_d  = lim;
            ftemp_d = lim;
            head_ra = ny_q;
            state_d = S_DPH;
          end
        end
      end
      S_DPH: begin
        fedge_d = head_rd;
        state_d = S_DE;
      end
      S_DRET: begin
        if (sp_q == '0) begin
          if (ret != '0) begin
            total_d = (tsum > (ValW + 1)'(FlowMax)) ? FlowMax : tsum[ValW-1:0];
            state_d = S_DST;
          end else begin
            clr_d   = '0;
            state_d = S_BCLR;
          end
        end else begin
          stk_ra  = sp_q - NW'(1);
          sp_d    = sp_q - NW'(1);
          ret_d   = ret;
          state_d = S_DP1;
        end
      end
      S_DP1: begin
        fnode_d = stk_rd[FW-1 -: NW];
        fedge_d = stk_rd[2*ResW +: EW];
        flim_d  = stk_rd[ResW +: ResW];
        ftemp_d = stk_rd[ResW-1:0];
        lnk_ra  = stk_rd[2*ResW +: EW];
        res_ra  = PW'(stk_rd[2*ResW +: EW] >> 1);
        state_d = S_DP2;
      end
      S_DP2: begin
        rf_d = fedge_q[0] ? res_rd[2*ResW-1:ResW] : res_rd[ResW-1:0];
        rr_d = fedge_q[0] ? res_rd[ResW-1:0] : res_rd[2*ResW-1:ResW];
        if (ret_q == '0) begin
          lvl_we = 1'b1;
          lvl_wa = lnk_rd[KW-1 -: NW];
        end
        res_we  = 1'b1;
        res_wa  = PW'(fedge_q >> 1);
        res_wd  = pack_pair(fedge_q[0], rf_d - ret_q, sat_add(rr_d, ret_q));
        ftemp_d = ftemp_q - ret_q;
        fedge_d = lnk_rd[EW-1:0];
        state_d = S_DE;
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HCLR;
      clr_q   <= '0;
      ecnt_q  <= EW'(1);
      src_q   <= 7'd0;
      snk_q   <= 7'd127;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ecnt_q  <= ecnt_d;
      if (cfg_we_i && cfg_index_i == CfgSource) begin
        src_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == CfgSink) begin
        snk_q <= cfg_data_i;
      end
      if (state_q == S_OUT && out_free) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; s_q <= s_d; t_q <= t_d;
    ny_q <= ny_d; fnode_q <= fnode_d; sp_q <= sp_d; qh_q <= qh_d; qt_q <= qt_d;
    cap_q <= cap_d; rf_q <= rf_d; rr_q <= rr_d; flim_q <= flim_d; ftemp_q <= ftemp_d;
    ret_q <= ret_d; n_q <= n_d; lx_q <= lx_d; fedge_q <= fedge_d; nxt_q <= nxt_d;
    total_q <= total_d; val_q <= val_d; stat_q <= stat_d;
    if (state_q == S_OUT && out_free) begin
      rv_q <= val_q;
      st_q <= stat_q;
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = ov_q;
  assign result_value_o = rv_q;
  assign status_o       = st_q;

`ifndef SYNTHESIS
  a_rise_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q == S_OUT)) else $error("result without completion");
  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BDEQ) |-> (qh_q <= qt_q && qt_q <= (NW + 1)'(NODES)))
    else $error("level queue pointers crossed");
  a_push_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DE) |-> (ftemp_q <= flim_q)) else $error("push budget exceeded limit");
  a_pair_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ecnt_q[0]) else $error("edge count lost pair alignment");
`endif

endmodule
`default_nettype wire

// ----- hdl/dmf_ram.sv -----
// generic simple dual-port ram with registered read
`default_nettype none
module dmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire
